[hdl/eod_pkg.sv]
`timescale 1ns / 1ps

package eod_pkg;

   // car geometry
   localparam int FLOORS   = 4;
   localparam int FLOOR_W  = 2;                      // fixed width of a floor field
   localparam int TARGET_W = 3;                      // width of the target floor register
   localparam int CNT_W    = $clog2(FLOORS + 1);     // request queue fill count
   localparam int QIDX_W   = (FLOORS > 1) ? $clog2(FLOORS) : 1;
   localparam int BTN_KINDS = 3;

   typedef logic [FLOOR_W-1:0] floor_type;
   typedef logic [BTN_KINDS-1:0] orders_type;        // one bit per button kind
   typedef logic signed [1:0] motor_type;

   // event kinds
   typedef enum logic {
      CMD_ORDER   = 1'b0,
      CMD_ARRIVAL = 1'b1
   } cmd_type;

   // button kinds, the last code is unused
   localparam logic [1:0] BTN_HALL_UP   = 2'd0;
   localparam logic [1:0] BTN_HALL_DOWN = 2'd1;
   localparam logic [1:0] BTN_CAB       = 2'd2;

   // motor commands
   localparam motor_type MOTOR_DOWN = -2'sd1;
   localparam motor_type MOTOR_STOP = 2'sd0;
   localparam motor_type MOTOR_UP   = 2'sd1;

endpackage

[hdl/elevator_order_dispatcher_unit.sv]
`timescale 1ns / 1ps

// channel    | direction | ports                                   | handshake
// -----------+-----------+-----------------------------------------+---------------------------
// request    | in        | req_cmd, req_button, req_floor          | start & !busy
// response   | out       | rsp_motor_dir, rsp_motor_write,         | rsp_strobe, one cycle,
//            |           | rsp_door_open, rsp_indicator_floor,     | cannot be held off
//            |           | rsp_lamp_set, rsp_lamps_cleared         |
//
// one request per clock cycle; the response reaches the rsp_ ports through two registers
// (input register, then the order table / queue update into the response register)
// the 4-entry request queue and the order table are checked in parallel, combinationally
// busy is high only while reset is held; synchronous reset clears orders, queue fill count and direction
// the receiver cannot stall, so nothing ever backs up behind a response

module elevator_order_dispatcher_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_cmd,
   input  logic [1:0]             req_button,
   input  eod_pkg::floor_type     req_floor,
   output logic                   rsp_strobe,
   output eod_pkg::motor_type     rsp_motor_dir,
   output logic                   rsp_motor_write,
   output logic                   rsp_door_open,
   output eod_pkg::floor_type     rsp_indicator_floor,
   output logic                   rsp_lamp_set,
   output logic                   rsp_lamps_cleared
);
   import eod_pkg::*;

   // input register
   logic              in_valid_ff;
   logic              in_cmd_ff;
   logic [1:0]        in_button_ff;
   floor_type         in_floor_ff;

   // dispatcher state
   orders_type [FLOORS-1:0]    pending_ff, pending_in;
   floor_type  [FLOORS-1:0]    queue_ff, queue_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       going_down_ff, going_down_in;
   floor_type                  last_floor_ff, last_floor_in;
   logic [TARGET_W-1:0]        target_ff, target_in;
   logic                       target_valid_ff, target_valid_in;

   // response register
   logic              rsp_strobe_ff;
   motor_type         motor_ff, motor_in;
   logic              mwrite_ff, mwrite_in;
   logic              door_ff, door_in;
   logic              lamp_ff, lamp_in;
   logic              cleared_ff, cleared_in;

   // queue lookup and removal
   logic                       hit;
   logic [CNT_W-1:0]           hit_pos;
   floor_type  [FLOORS-1:0]    queue_rm;
   logic                       floor_ok;
   logic                       stop_here;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
      in_cmd_ff    <= req_cmd;
      in_button_ff <= req_button;
      in_floor_ff  <= req_floor;
   end

   // find the request floor among the queued entries (queue never holds duplicates)
   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      for (int i = 0; i < FLOORS; i++) begin
         if (!hit && (CNT_W'(i) < count_ff) && (queue_ff[i] == in_floor_ff)) begin
            hit     = 1'b1;
            hit_pos = CNT_W'(i);
         end
      end
   end

   // queue with the matching entry squeezed out
   always_comb begin
      for (int j = 0; j < FLOORS; j++) begin
         if ((CNT_W'(j) >= hit_pos) && (j < FLOORS - 1)) begin
            queue_rm[j] = queue_ff[(j + 1) % FLOORS];
         end else begin
            queue_rm[j] = queue_ff[j];
         end
      end
   end

   assign floor_ok  = int'(in_floor_ff) < FLOORS;
   assign stop_here = pending_ff[in_floor_ff][{1'b0, going_down_ff}]
                    | pending_ff[in_floor_ff][BTN_CAB];

   always_comb begin
      pending_in      = pending_ff;
      queue_in        = queue_ff;
      count_in        = count_ff;
      going_down_in   = going_down_ff;
      last_floor_in   = last_floor_ff;
      target_in       = target_ff;
      target_valid_in = target_valid_ff;
      motor_in        = MOTOR_STOP;
      mwrite_in       = 1'b0;
      door_in         = 1'b0;
      lamp_in         = 1'b0;
      cleared_in      = 1'b0;

      if (in_valid_ff && floor_ok) begin
         if (in_cmd_ff == CMD_ORDER) begin
            // unknown button code changes no state and sets no response flag
            if (in_button_ff inside {BTN_HALL_UP, BTN_HALL_DOWN, BTN_CAB}) begin
               pending_in[in_floor_ff][in_button_ff] = 1'b1;
               if (!hit && (int'(count_ff) < FLOORS)) begin
                  queue_in[count_ff[QIDX_W-1:0]] = in_floor_ff;
                  count_in = count_ff + CNT_W'(1);
               end
               lamp_in = 1'b1;
            end
         end else begin
            last_floor_in = in_floor_ff;
            // stop for a cab order or a hall order in the travel direction
            if (stop_here) begin
               pending_in[in_floor_ff] = '0;
               door_in    = 1'b1;
               cleared_in = 1'b1;
               if (hit) begin
                  queue_in = queue_rm;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            // target reached: pull the next one from the queue head
            if (target_valid_ff && (target_ff == {1'b0, in_floor_ff})) begin
               target_valid_in = (count_in != '0);
               if (count_in != '0) begin
                  target_in = {1'b0, queue_in[0]};
               end
            end
            if (!target_valid_in) begin
               // nothing to do: park, keep direction, try the head again
               motor_in        = MOTOR_STOP;
               target_valid_in = (count_in != '0);
               if (count_in != '0) begin
                  target_in = {1'b0, queue_in[0]};
               end
            end else if (target_in < {1'b0, in_floor_ff}) begin
               motor_in      = MOTOR_DOWN;
               going_down_in = 1'b1;
            end else if (target_in > {1'b0, in_floor_ff}) begin
               motor_in      = MOTOR_UP;
               going_down_in = 1'b0;
            end else if (!going_down_ff) begin
               // overshoot: turn around
               motor_in      = MOTOR_DOWN;
               going_down_in = 1'b1;
            end else begin
               motor_in      = MOTOR_UP;
               going_down_in = 1'b0;
            end
            mwrite_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= '0;
         count_ff        <= '0;
         going_down_ff   <= 1'b0;
         last_floor_ff   <= '0;
         target_ff       <= '0;
         target_valid_ff <= 1'b1;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         pending_ff      <= pending_in;
         count_ff        <= count_in;
         going_down_ff   <= going_down_in;
         last_floor_ff   <= last_floor_in;
         target_ff       <= target_in;
         target_valid_ff <= target_valid_in;
         rsp_strobe_ff   <= in_valid_ff;
      end
      queue_ff   <= queue_in;
      motor_ff   <= motor_in;
      mwrite_ff  <= mwrite_in;
      door_ff    <= door_in;
      lamp_ff    <= lamp_in;
      cleared_ff <= cleared_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_motor_dir       = motor_ff;
   assign rsp_motor_write     = mwrite_ff;
   assign rsp_door_open       = door_ff;
   assign rsp_indicator_floor = last_floor_ff;
   assign rsp_lamp_set        = lamp_ff;
   assign rsp_lamps_cleared   = cleared_ff;

`ifndef NO_ASSERTIONS
   // every accepted request gets its response strobe after the input and response registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("response missing for accepted request");

   // an order never drives the motor, an arrival never lights a lamp
   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_lamp_set && rsp_motor_write))
      else $error("order and arrival flags both set");

   // a door opening only happens on an arrival and clears the lamps
   a_door_arrival: assert property (@(posedge clock) disable iff (reset)
      rsp_door_open |-> (rsp_motor_write && rsp_lamps_cleared))
      else $error("door opened outside an arrival");

   // the queue fill count stays within the number of floors
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= FLOORS)
      else $error("request queue overfilled");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import eod_pkg::*;

   localparam int NUM_RANDOM  = 1300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 8;                 // well past the registered response path
   localparam logic [1:0] BTN_UNUSED = 2'd3;       // the one button code the block ignores

   // one request as the driver presents it
   typedef struct {
      cmd_type     cmd;
      logic [1:0]  button;
      floor_type   floor;
      int unsigned gap;      // idle cycles before the request goes out
      bit          drain;    // hold the request until every response is back
   } car_event_type;

   // one response, field for field as on the rsp_ ports
   typedef struct {
      motor_type motor_dir;
      logic      motor_write;
      logic      door_open;
      floor_type indicator_floor;
      logic      lamp_set;
      logic      lamps_cleared;
   } car_rsp_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic      req_cmd = 1'b0;
   logic [1:0] req_button = 2'd0;
   floor_type req_floor = '0;
   logic      rsp_strobe;
   motor_type rsp_motor_dir;
   logic      rsp_motor_write;
   logic      rsp_door_open;
   floor_type rsp_indicator_floor;
   logic      rsp_lamp_set;
   logic      rsp_lamps_cleared;

   elevator_order_dispatcher_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_button          (req_button),
      .req_floor           (req_floor),
      .rsp_strobe          (rsp_strobe),
      .rsp_motor_dir       (rsp_motor_dir),
      .rsp_motor_write     (rsp_motor_write),
      .rsp_door_open       (rsp_door_open),
      .rsp_indicator_floor (rsp_indicator_floor),
      .rsp_lamp_set        (rsp_lamp_set),
      .rsp_lamps_cleared   (rsp_lamps_cleared)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   car_event_type  event_q[$];          // requests waiting for the driver
   car_rsp_type    expected_rsp_q[$];   // responses predicted, oldest first
   int             fail_cnt  = 0;
   int unsigned    cycle_cnt = 0;

   // ---------------------------------------------------------------
   // dispatcher state as the testbench sees it
   // ---------------------------------------------------------------
   orders_type         car_orders [FLOORS];   // hall up, hall down, cab per floor
   floor_type          queued_floor [FLOORS]; // first-come floor queue
   int                 queued_cnt   = 0;
   logic               going_down   = 1'b0;
   floor_type          car_floor    = '0;
   logic [TARGET_W-1:0] aim_floor   = '0;
   logic               aim_valid    = 1'b1;   // after reset the car aims at floor 0

   initial begin
      foreach (car_orders[i]) car_orders[i] = '0;
      foreach (queued_floor[i]) queued_floor[i] = '0;
   end

   // motor command, a nonzero one also sets the travel direction
   function automatic motor_type steer(motor_type dir);
      if (dir == MOTOR_DOWN)
         going_down = 1'b1;
      else if (dir == MOTOR_UP)
         going_down = 1'b0;
      return dir;
   endfunction

   // next target from the head of the floor queue, none if it is empty
   function automatic void aim_at_head();
      if (queued_cnt > 0) begin
         aim_floor = {1'b0, queued_floor[0]};
         aim_valid = 1'b1;
      end else begin
         aim_valid = 1'b0;
      end
   endfunction

   // applies one request to the state and returns the response it causes
   function automatic car_rsp_type dispatch_event(cmd_type cmd, logic [1:0] btn, floor_type fl);
      car_rsp_type r;
      bit          queued;
      int          pos;
      r = '{motor_dir: MOTOR_STOP, motor_write: 1'b0, door_open: 1'b0,
            indicator_floor: '0, lamp_set: 1'b0, lamps_cleared: 1'b0};
      if (int'(fl) < FLOORS) begin
         if (cmd == CMD_ORDER) begin
            if (btn != BTN_UNUSED) begin
               car_orders[fl][btn] = 1'b1;
               queued = 1'b0;
               for (int i = 0; i < queued_cnt; i++)
                  if (queued_floor[i] == fl) queued = 1'b1;
               // a full queue still takes the order bit and the lamp
               if (!queued && queued_cnt < FLOORS) begin
                  queued_floor[queued_cnt] = fl;
                  queued_cnt++;
               end
               r.lamp_set = 1'b1;
            end
         end else begin
            car_floor = fl;
            // stop for an order in the travel direction or any cab order
            if (car_orders[fl][going_down] || car_orders[fl][BTN_CAB]) begin
               r.motor_dir     = steer(MOTOR_STOP);
               r.door_open     = 1'b1;
               r.lamps_cleared = 1'b1;
               car_orders[fl]  = '0;
               pos = -1;
               for (int i = 0; i < queued_cnt; i++)
                  if (pos < 0 && queued_floor[i] == fl) pos = i;
               if (pos >= 0) begin
                  for (int j = pos; j + 1 < queued_cnt; j++)
                     queued_floor[j] = queued_floor[j + 1];
                  queued_cnt--;
               end
            end
            if (aim_valid && aim_floor == {1'b0, fl})
               aim_at_head();
            if (!aim_valid) begin
               // nothing to go for: stop, keep the direction
               r.motor_dir = steer(MOTOR_STOP);
               aim_at_head();
            end else if (aim_floor < {1'b0, car_floor}) begin
               r.motor_dir = steer(MOTOR_DOWN);
            end else if (aim_floor > {1'b0, car_floor}) begin
               r.motor_dir = steer(MOTOR_UP);
            end else if (!going_down) begin
               // target is the floor just reached: overshoot, turn around
               r.motor_dir = steer(MOTOR_DOWN);
            end else begin
               r.motor_dir = steer(MOTOR_UP);
            end
            r.motor_write = 1'b1;
         end
      end
      r.indicator_floor = car_floor;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // driver: presents requests from event_q, predicts on acceptance
   // ---------------------------------------------------------------
   car_event_type cur_event;
   bit            have_event = 1'b0;
   int unsigned   wait_left  = 0;
   motor_type     last_drive = MOTOR_STOP;   // steers the stimulus car walk

   always @(posedge clock) begin : driver
      car_rsp_type exp_rsp;
      logic        nxt_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            exp_rsp = dispatch_event(cmd_type'(req_cmd), req_button, req_floor);
            expected_rsp_q.push_back(exp_rsp);
            if (req_cmd == CMD_ARRIVAL)
               last_drive = exp_rsp.motor_dir;
         end
         // a request not yet taken stays up
         nxt_start = start && busy;
         if (!nxt_start) begin
            if (!have_event && event_q.size() > 0) begin
               cur_event  = event_q.pop_front();
               have_event = 1'b1;
               wait_left  = cur_event.gap;
            end
            if (have_event) begin
               if (wait_left > 0) begin
                  wait_left--;
               end else if (!cur_event.drain || expected_rsp_q.size() == 0) begin
                  req_cmd    <= cur_event.cmd;
                  req_button <= cur_event.button;
                  req_floor  <= cur_event.floor;
                  nxt_start  = 1'b1;
                  have_event = 1'b0;
               end
            end
         end
         start <= nxt_start;
      end
   end

   // ---------------------------------------------------------------
   // monitor: every strobe must match the oldest prediction
   // ---------------------------------------------------------------
   task automatic check_field(string what, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
         fail_cnt++;
      end
   endtask

   always @(posedge clock) begin : monitor
      car_rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            fail_cnt++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            check_field("motor_dir", int'(exp_rsp.motor_dir), int'(rsp_motor_dir));
            check_field("motor_write", int'(exp_rsp.motor_write), int'(rsp_motor_write));
            check_field("door_open", int'(exp_rsp.door_open), int'(rsp_door_open));
            check_field("indicator_floor", int'(exp_rsp.indicator_floor),
                        int'(rsp_indicator_floor));
            check_field("lamp_set", int'(exp_rsp.lamp_set), int'(rsp_lamp_set));
            check_field("lamps_cleared", int'(exp_rsp.lamps_cleared), int'(rsp_lamps_cleared));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_event(cmd_type cmd, logic [1:0] btn, floor_type fl,
                             int unsigned gap, bit drain);
      car_event_type ev;
      ev.cmd    = cmd;
      ev.button = btn;
      ev.floor  = fl;
      ev.gap    = gap;
      ev.drain  = drain;
      event_q.push_back(ev);
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      int          counted;
      int          car_pos;
      int          pick;
      bit          idle_mode;
      logic [1:0]  btn;
      int unsigned gap;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // arrival with nothing queued: target is dropped, motor stops
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd0, 0, 1'b0);
      // unknown button code is ignored
      push_event(CMD_ORDER, BTN_UNUSED, 2'd2, 1, 1'b0);
      // every button kind, lowest and highest floors
      push_event(CMD_ORDER, BTN_HALL_UP, 2'd0, 0, 1'b0);
      push_event(CMD_ORDER, BTN_HALL_DOWN, 2'd3, 0, 1'b0);
      push_event(CMD_ORDER, BTN_CAB, 2'd1, 2, 1'b0);
      push_event(CMD_ORDER, BTN_HALL_UP, 2'd2, 0, 1'b0);
      push_event(CMD_ORDER, BTN_HALL_DOWN, 2'd1, 0, 1'b0);
      push_event(CMD_ORDER, BTN_CAB, 2'd3, 0, 1'b0);
      // floor already queued
      push_event(CMD_ORDER, BTN_CAB, 2'd2, 0, 1'b0);
      // run the car up and back down through the queue
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd0, 0, 1'b0);
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd1, 1, 1'b0);
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd2, 0, 1'b0);
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd3, 0, 1'b0);
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd2, 0, 1'b0);
      push_event(CMD_ORDER, BTN_HALL_DOWN, 2'd0, 0, 1'b0);
      push_event(CMD_ORDER, BTN_HALL_UP, 2'd1, 0, 1'b0);
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd1, 3, 1'b0);
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd0, 0, 1'b0);
      // overshoot: reach the target floor without an order there
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd1, 0, 1'b0);
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd1, 0, 1'b0);
      // idle car after all requests are served, drained first
      push_event(CMD_ARRIVAL, BTN_HALL_UP, 2'd3, 0, 1'b1);

      // random part: a car walking the shaft, orders coming in between
      counted   = 0;
      car_pos   = 0;
      idle_mode = 1'b0;
      while (counted < NUM_RANDOM) begin
         // keep the queue short so the walk follows the motor
         while (event_q.size() > 1) @(posedge clock);
         if (counted % 40 == 0)
            idle_mode = 1'($urandom_range(0, 1));
         gap = idle_mode ? $urandom_range(0, 10) : 0;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            btn = ($urandom_range(0, 19) == 0) ? BTN_UNUSED : 2'($urandom_range(0, 2));
            push_event(CMD_ORDER, btn, floor_type'($urandom_range(0, FLOORS - 1)), gap,
                       counted % 300 == 150);
            if (btn != BTN_UNUSED) counted++;
         end else begin
            if (pick < 88) begin
               if (last_drive == MOTOR_UP && car_pos < FLOORS - 1)
                  car_pos++;
               else if (last_drive == MOTOR_DOWN && car_pos > 0)
                  car_pos--;
               else if ($urandom_range(0, 1) && car_pos < FLOORS - 1)
                  car_pos++;
               else if (car_pos > 0)
                  car_pos--;
            end else begin
               // noise: a sensor anywhere in the shaft
               car_pos = $urandom_range(0, FLOORS - 1);
            end
            push_event(CMD_ARRIVAL, 2'($urandom_range(0, 3)), floor_type'(car_pos), gap,
                       counted % 300 == 150);
            counted++;
         end
      end

      // wait for every request to go out and every response to come back
      while (event_q.size() != 0 || have_event || start || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_cnt == 0 && expected_rsp_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
hdl/eod_pkg.sv
hdl/elevator_order_dispatcher_unit.sv
dv/tb.sv
